/* rtl/core/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared widths, vector types and constants of the quaternion to rotation
// matrix datapath.
// ----------------------------------------------------------------------------
package qrm_pkg;

  // Field and datapath widths
  localparam int COMP_W    = 16;  // quaternion component, Q2.14
  localparam int PROD_W    = 32;  // product of two components
  localparam int NORM_W    = 33;  // sum of four squares, unsigned
  localparam int NUM_W     = 34;  // signed numerator of one matrix entry
  localparam int MAG_W     = 33;  // numerator magnitude and divider remainder
  localparam int QUO_W     = 16;  // quotient bits, one extra bit for rounding
  localparam int ENTRY_W   = 16;  // matrix entry, Q2.14
  localparam int LANES     = 9;   // matrix entries, row then column

  // Entries on the main diagonal (r00, r11, r22)
  localparam logic [LANES-1:0] DIAG_MASK = 9'b100010001;

  // 1.0 in Q2.14
  localparam logic signed [ENTRY_W-1:0] ONE_Q = 16'sd16384;

  // Largest positive entry
  localparam logic signed [ENTRY_W:0] ENTRY_MAX = 17'sd32767;

  typedef logic [LANES-1:0][MAG_W-1:0] mag_vec_t;
  typedef logic [LANES-1:0][QUO_W-1:0] quo_vec_t;

  // Per-item side information carried alongside the divider
  typedef struct packed {
    logic [LANES-1:0] neg;    // numerator sign per entry
    logic             degen;  // zero quaternion
  } side_t;

endpackage

/* rtl/core/qrm_div.sv */
// ----------------------------------------------------------------------------
// qrm_div
// Pipelined restoring divider for all nine entries: one quotient bit per
// stage, shared denominator, side information travels with each item.
// ----------------------------------------------------------------------------
module qrm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [qrm_pkg::NORM_W-1:0] in_den,
  input  qrm_pkg::mag_vec_t          in_mag,
  input  qrm_pkg::side_t             in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output qrm_pkg::quo_vec_t          out_quo,
  output qrm_pkg::side_t             out_side
);

  localparam int Steps = qrm_pkg::QUO_W;
  localparam int Lanes = qrm_pkg::LANES;
  localparam int MagW  = qrm_pkg::MAG_W;

  // Stage registers
  logic [Steps-1:0]                v_r;
  logic [qrm_pkg::NORM_W-1:0]      den_r  [Steps];
  qrm_pkg::mag_vec_t               rem_r  [Steps];
  qrm_pkg::quo_vec_t               quo_r  [Steps];
  qrm_pkg::side_t                  side_r [Steps];

  // Stage inputs and next values
  logic [Steps-1:0]                st_v;
  logic [qrm_pkg::NORM_W-1:0]      st_den [Steps];
  qrm_pkg::mag_vec_t               st_rem [Steps];
  qrm_pkg::quo_vec_t               st_quo [Steps];
  qrm_pkg::side_t                  st_side[Steps];
  qrm_pkg::mag_vec_t               rem_nxt[Steps];
  qrm_pkg::quo_vec_t               quo_nxt[Steps];
  logic [Steps:0]                  adv;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[Steps] = out_ready;
    for (int s = Steps - 1; s >= 0; s--) begin
      adv[s] = !v_r[s] || adv[s+1];
    end
  end

  assign in_ready = adv[0];

  // Select the operands each stage works on
  always_comb begin
    st_v[0]    = in_valid;
    st_den[0]  = in_den;
    st_rem[0]  = in_mag;
    st_quo[0]  = '0;
    st_side[0] = in_side;
    for (int s = 1; s < Steps; s++) begin
      st_v[s]    = v_r[s-1];
      st_den[s]  = den_r[s-1];
      st_rem[s]  = rem_r[s-1];
      st_quo[s]  = quo_r[s-1];
      st_side[s] = side_r[s-1];
    end
  end

  // One restoring step per stage and lane: shift, compare, subtract
  always_comb begin
    logic [MagW:0] trial;
    logic [MagW:0] diff;
    logic          ge;
    for (int s = 0; s < Steps; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        // First step compares the magnitude itself (integer quotient bit)
        if (s == 0) begin
          trial = {1'b0, st_rem[s][l]};
        end else begin
          trial = {st_rem[s][l], 1'b0};
        end
        diff = trial - {1'b0, st_den[s]};
        ge   = trial >= {1'b0, st_den[s]};
        rem_nxt[s][l] = ge ? diff[MagW-1:0] : trial[MagW-1:0];
        quo_nxt[s][l] = {st_quo[s][l][Steps-2:0], ge};
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < Steps; s++) begin
        if (adv[s]) begin
          v_r[s] <= st_v[s];
        end
      end
    end
  end

  // Payload: load only when an item moves in
  always_ff @(posedge clk) begin
    for (int s = 0; s < Steps; s++) begin
      if (adv[s] && st_v[s]) begin
        den_r[s]  <= st_den[s];
        rem_r[s]  <= rem_nxt[s];
        quo_r[s]  <= quo_nxt[s];
        side_r[s] <= st_side[s];
      end
    end
  end

  assign out_valid = v_r[Steps-1];
  assign out_quo   = quo_r[Steps-1];
  assign out_side  = side_r[Steps-1];

endmodule

/* rtl/core/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts one Q2.14 quaternion per item into the nine Q2.14 entries of the
// rotation matrix of its normalized form.
// ----------------------------------------------------------------------------
// The block accepts one quaternion every clock cycle while the output side does
// not stall. The path has 20 register stages: one of component products, one
// of numerator and norm sums, one of sign and magnitude split, 16 stages of a
// restoring divider that produces one quotient bit per stage for all nine
// entries at once, and one stage that rounds to nearest (ties away from zero),
// restores the sign and saturates. The divider depth sets the latency. Every
// stage holds its item on a stall and fills bubbles, so input is taken while a
// finished result waits, until every stage is full.
// A zero quaternion gives the identity matrix with out_degenerate set.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [qrm_pkg::COMP_W-1:0]  in_quat_x,
  input  logic signed [qrm_pkg::COMP_W-1:0]  in_quat_y,
  input  logic signed [qrm_pkg::COMP_W-1:0]  in_quat_z,
  input  logic signed [qrm_pkg::COMP_W-1:0]  in_quat_w,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qrm_pkg::ENTRY_W-1:0] out_r00,
  output logic signed [qrm_pkg::ENTRY_W-1:0] out_r01,
  output logic signed [qrm_pkg::ENTRY_W-1:0] out_r02,
  output logic signed [qrm_pkg::ENTRY_W-1:0] out_r10,
  output logic signed [qrm_pkg::ENTRY_W-1:0] out_r11,
  output logic signed [qrm_pkg::ENTRY_W-1:0] out_r12,
  output logic signed [qrm_pkg::ENTRY_W-1:0] out_r20,
  output logic signed [qrm_pkg::ENTRY_W-1:0] out_r21,
  output logic signed [qrm_pkg::ENTRY_W-1:0] out_r22,
  output logic                               out_degenerate
);

  localparam int Lanes  = qrm_pkg::LANES;
  localparam int ProdW  = qrm_pkg::PROD_W;
  localparam int NormW  = qrm_pkg::NORM_W;
  localparam int NumW   = qrm_pkg::NUM_W;
  localparam int MagW   = qrm_pkg::MAG_W;
  localparam int QuoW   = qrm_pkg::QUO_W;
  localparam int EntryW = qrm_pkg::ENTRY_W;

  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [NumW-1:0]  num_t;

  // Sign-extend a product to numerator width
  function automatic num_t sx(input prod_t a);
    return {{(NumW-ProdW){a[ProdW-1]}}, a};
  endfunction

  // Twice a sum or difference of two products
  function automatic num_t dbl(input prod_t a, input prod_t b, input logic sub);
    num_t s;
    s = sub ? (sx(a) - sx(b)) : (sx(a) + sx(b));
    return {s[NumW-2:0], 1'b0};
  endfunction

  // Pipeline control
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic adv1, adv2, adv3, adv_o;
  logic div_in_ready, div_out_valid;

  // Stage 1: products
  prod_t xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;

  // Stage 2: norm and numerators
  logic [NormW-1:0] n2_r, n2_nxt;
  num_t             num_r [Lanes];
  num_t             num_nxt [Lanes];

  // Stage 3: sign and magnitude
  logic [NormW-1:0]  den3_r;
  qrm_pkg::mag_vec_t mag3_r, mag3_nxt;
  qrm_pkg::side_t    side3_r, side3_nxt;

  // Divider result
  qrm_pkg::quo_vec_t div_quo;
  qrm_pkg::side_t    div_side;

  // Output stage
  logic signed [EntryW-1:0] res_r [Lanes];
  logic signed [EntryW-1:0] res_nxt [Lanes];
  logic                     degen_r;

  // Advance each stage when empty or when its successor advances
  assign adv_o    = !out_valid_r || out_ready;
  assign adv3     = !v3_r || div_in_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv_o) begin
        out_valid_r <= div_out_valid;
      end
    end
  end

  // Stage 1: form all component products
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      xx_r <= in_quat_x * in_quat_x;
      yy_r <= in_quat_y * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;
      ww_r <= in_quat_w * in_quat_w;
      xy_r <= in_quat_x * in_quat_y;
      xz_r <= in_quat_x * in_quat_z;
      yz_r <= in_quat_y * in_quat_z;
      xw_r <= in_quat_x * in_quat_w;
      yw_r <= in_quat_y * in_quat_w;
      zw_r <= in_quat_z * in_quat_w;
    end
  end

  // Stage 2: squared norm and entry numerators
  always_comb begin
    n2_nxt = {2'b00, xx_r[ProdW-2:0]} + {2'b00, yy_r[ProdW-2:0]}
           + {2'b00, zz_r[ProdW-2:0]} + {2'b00, ww_r[ProdW-2:0]};
    num_nxt[0] = sx(ww_r) + sx(xx_r) - sx(yy_r) - sx(zz_r);
    num_nxt[1] = dbl(xy_r, zw_r, 1'b1);
    num_nxt[2] = dbl(xz_r, yw_r, 1'b0);
    num_nxt[3] = dbl(xy_r, zw_r, 1'b0);
    num_nxt[4] = sx(ww_r) + sx(yy_r) - sx(xx_r) - sx(zz_r);
    num_nxt[5] = dbl(yz_r, xw_r, 1'b1);
    num_nxt[6] = dbl(xz_r, yw_r, 1'b1);
    num_nxt[7] = dbl(yz_r, xw_r, 1'b0);
    num_nxt[8] = sx(ww_r) + sx(zz_r) - sx(xx_r) - sx(yy_r);
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      n2_r <= n2_nxt;
      for (int l = 0; l < Lanes; l++) begin
        num_r[l] <= num_nxt[l];
      end
    end
  end

  // Stage 3: split numerators into sign and magnitude, flag a zero norm
  always_comb begin
    num_t a;
    for (int l = 0; l < Lanes; l++) begin
      a = num_r[l][NumW-1] ? -num_r[l] : num_r[l];
      mag3_nxt[l]      = a[MagW-1:0];
      side3_nxt.neg[l] = num_r[l][NumW-1];
    end
    side3_nxt.degen = (n2_r == '0);
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      den3_r  <= n2_r;
      mag3_r  <= mag3_nxt;
      side3_r <= side3_nxt;
    end
  end

  // Divide every magnitude by the norm, 2^15 scaled
  qrm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_in_ready),
    .in_den    (den3_r),
    .in_mag    (mag3_r),
    .in_side   (side3_r),
    .out_valid (div_out_valid),
    .out_ready (adv_o),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // Output stage: round half up on the magnitude, restore sign, saturate
  always_comb begin
    logic [QuoW:0]          rnd;
    logic signed [EntryW:0] sv;
    for (int l = 0; l < Lanes; l++) begin
      rnd = {1'b0, div_quo[l]} + {{QuoW{1'b0}}, 1'b1};
      sv  = div_side.neg[l] ? -$signed({1'b0, rnd[QuoW:1]}) : $signed({1'b0, rnd[QuoW:1]});
      if (sv > qrm_pkg::ENTRY_MAX) begin
        sv = qrm_pkg::ENTRY_MAX;
      end
      res_nxt[l] = sv[EntryW-1:0];
      // Zero quaternion: substitute the identity
      if (div_side.degen) begin
        res_nxt[l] = qrm_pkg::DIAG_MASK[l] ? qrm_pkg::ONE_Q : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o && div_out_valid) begin
      degen_r <= div_side.degen;
      for (int l = 0; l < Lanes; l++) begin
        res_r[l] <= res_nxt[l];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_r00        = res_r[0];
  assign out_r01        = res_r[1];
  assign out_r02        = res_r[2];
  assign out_r10        = res_r[3];
  assign out_r11        = res_r[4];
  assign out_r12        = res_r[5];
  assign out_r20        = res_r[6];
  assign out_r21        = res_r[7];
  assign out_r22        = res_r[8];
  assign out_degenerate = degen_r;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quaternion_to_rotation_matrix. Sends directed and
// random quaternions through the valid/ready input with random gaps, stalls
// the result side at random, predicts each rotation matrix with exact integer
// rounding and compares every result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CW          = qrm_pkg::COMP_W;
  localparam int EW          = qrm_pkg::ENTRY_W;
  localparam int RAND_ITEMS  = 1850;
  localparam int SEG_ITEMS   = 150;
  localparam int DRAIN_CYC   = 40;
  localparam int CYCLE_LIMIT = 900000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic signed [EW-1:0] entry [9];
    logic                 degenerate;
  } rot_matrix_t;

  // Predict results and hold them in acceptance order
  class rotation_scoreboard;
    rot_matrix_t pending_mats[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    // round(num * 2^14 / den), ties away from zero, then clamp to Q2.14
    function logic signed [EW-1:0] q14_ratio(longint num, longint unsigned den);
      bit              neg;
      longint unsigned mag;
      longint unsigned quo;
      longint          res;
      neg = num < 0;
      mag = neg ? longint'(-num) : longint'(num);
      quo = ((mag << 15) + den) / (den << 1);
      if (quo > 64'd32768) quo = 64'd32768;
      res = neg ? -longint'(quo) : longint'(quo);
      if (res > 32767) res = 32767;
      return res[EW-1:0];
    endfunction

    function rot_matrix_t quat_to_matrix(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
                                         logic signed [CW-1:0] qz, logic signed [CW-1:0] qw);
      rot_matrix_t     m;
      longint          x, y, z, w;
      longint          xx, yy, zz, ww;
      longint unsigned norm;
      x = qx; y = qy; z = qz; w = qw;
      xx = x * x; yy = y * y; zz = z * z; ww = w * w;
      norm = xx + yy + zz + ww;
      if (norm == 0) begin
        foreach (m.entry[i]) m.entry[i] = '0;
        m.entry[0] = qrm_pkg::ONE_Q;
        m.entry[4] = qrm_pkg::ONE_Q;
        m.entry[8] = qrm_pkg::ONE_Q;
        m.degenerate = 1'b1;
      end else begin
        m.entry[0] = q14_ratio(ww + xx - yy - zz, norm);
        m.entry[1] = q14_ratio(2 * (x * y - z * w), norm);
        m.entry[2] = q14_ratio(2 * (x * z + y * w), norm);
        m.entry[3] = q14_ratio(2 * (x * y + z * w), norm);
        m.entry[4] = q14_ratio(ww + yy - xx - zz, norm);
        m.entry[5] = q14_ratio(2 * (y * z - x * w), norm);
        m.entry[6] = q14_ratio(2 * (x * z - y * w), norm);
        m.entry[7] = q14_ratio(2 * (y * z + x * w), norm);
        m.entry[8] = q14_ratio(ww + zz - xx - yy, norm);
        m.degenerate = 1'b0;
      end
      return m;
    endfunction

    function void note_quat(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
                            logic signed [CW-1:0] qz, logic signed [CW-1:0] qw);
      pending_mats.insert(pending_mats.size(), quat_to_matrix(qx, qy, qz, qw));
    endfunction

    function void flag_error(string what, int exp_val, int got_val);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %0d, got %0d", what, exp_val, got_val);
    endfunction

    function void check_matrix(rot_matrix_t got);
      rot_matrix_t exp_m;
      if (pending_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: result item with no quaternion pending");
        return;
      end
      exp_m = pending_mats.pop_front();
      foreach (got.entry[i]) begin
        if (got.entry[i] !== exp_m.entry[i])
          flag_error($sformatf("r%0d%0d", i / 3, i % 3), exp_m.entry[i], got.entry[i]);
      end
      if (got.degenerate !== exp_m.degenerate)
        flag_error("degenerate", exp_m.degenerate, got.degenerate);
    endfunction

    function int outstanding();
      return pending_mats.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [CW-1:0] in_quat_x, in_quat_y, in_quat_z, in_quat_w;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [EW-1:0] out_r00, out_r01, out_r02;
  logic signed [EW-1:0] out_r10, out_r11, out_r12;
  logic signed [EW-1:0] out_r20, out_r21, out_r22;
  logic                 out_degenerate;

  rotation_scoreboard rot_sb;
  bit                 in_gaps_on;
  bit                 out_stalls_on;
  int                 cycle_count;

  quaternion_to_rotation_matrix uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_quat_x      (in_quat_x),
    .in_quat_y      (in_quat_y),
    .in_quat_z      (in_quat_z),
    .in_quat_w      (in_quat_w),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_r00        (out_r00),
    .out_r01        (out_r01),
    .out_r02        (out_r02),
    .out_r10        (out_r10),
    .out_r11        (out_r11),
    .out_r12        (out_r12),
    .out_r20        (out_r20),
    .out_r21        (out_r21),
    .out_r22        (out_r22),
    .out_degenerate (out_degenerate)
  );

  // Clock: period 4
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random component from one of several value classes
  function automatic logic signed [CW-1:0] pick_comp(int kind);
    logic signed [CW-1:0] corners [8];
    corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0,
                16'sd1, 16'sd32767, 16'sd16384, -16'sd16384};
    case (kind)
      0: begin
        return 16'($urandom());
      end
      1: begin
        return 16'($urandom_range(0, 16)) - 16'sd8;
      end
      2: begin
        return ($urandom_range(0, 2) == 0) ? 16'sd0 : 16'($urandom());
      end
      3: begin
        return corners[$urandom_range(0, 7)];
      end
      default: begin
        return 16'sd0;
      end
    endcase
  endfunction

  // Drive one quaternion at the falling edge and hold it until accepted
  task automatic send_quat(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
                           logic signed [CW-1:0] qz, logic signed [CW-1:0] qw);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid  = 1'b1;
    in_quat_x = qx;
    in_quat_y = qy;
    in_quat_z = qz;
    in_quat_w = qw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stall the result side at random
  initial begin
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!out_stalls_on) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // Note accepted quaternions and check accepted results
  always @(posedge clk) begin
    rot_matrix_t got;
    if (rst_n) begin
      if (in_valid && in_ready)
        rot_sb.note_quat(in_quat_x, in_quat_y, in_quat_z, in_quat_w);
      if (out_valid && out_ready) begin
        got.entry      = '{out_r00, out_r01, out_r02, out_r10, out_r11,
                           out_r12, out_r20, out_r21, out_r22};
        got.degenerate = out_degenerate;
        rot_sb.check_matrix(got);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int kind;
    int mode;
    int drain;
    rot_sb        = new();
    cycle_count   = 0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_quat_x     = '0;
    in_quat_y     = '0;
    in_quat_z     = '0;
    in_quat_w     = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero quaternion, axes, extremes, tiny norms
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd1);
    send_quat(16'sd1, 16'sd1, 16'sd1, 16'sd1);
    send_quat(-16'sd1, 16'sd2, -16'sd3, 16'sd4);
    send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
    send_quat(16'sd3, 16'sd0, 16'sd0, 16'sd1);
    send_quat(16'sd1, 16'sd1, 16'sd0, 16'sd0);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(-16'sd32768, 16'sd32767, -16'sd1, 16'sd1);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd5, -16'sd7, 16'sd0, 16'sd0);

    // Random: segments with different idling on each side
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % SEG_ITEMS == 0) begin
        mode          = $urandom_range(0, 3);
        in_gaps_on    = (mode == 0) || (mode == 2);
        out_stalls_on = (mode == 0) || (mode == 3);
      end
      kind = $urandom_range(0, 99);
      if (kind < 50) kind = 0;
      else if (kind < 70) kind = 1;
      else if (kind < 85) kind = 2;
      else if (kind < 95) kind = 3;
      else kind = 4;
      send_quat(pick_comp(kind), pick_comp(kind), pick_comp(kind), pick_comp(kind));
    end

    // Release the input and drain the pipeline
    @(negedge clk);
    in_valid = 1'b0;
    while (rot_sb.outstanding() != 0) @(posedge clk);
    for (drain = 0; drain < DRAIN_CYC; drain++) @(posedge clk);

    if (rot_sb.mismatches == 0 && rot_sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/qrm_pkg.sv
rtl/core/qrm_div.sv
rtl/core/quaternion_to_rotation_matrix.sv
dv/testbench.sv
